// ----- rtl/tcw_pkg.sv -----
// shared constants, types and state encoding for the text console writer
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = COLUMNS * ROWS;
  localparam int COPY_CELLS = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int CELL_W     = 16;
  localparam int CHAR_W     = 8;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int CUR_ROW_W  = $clog2(ROWS);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'd240;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SCROLL,
    ST_DRAIN
  } tcw_state_t;

  typedef struct packed {
    logic accept;
    logic sweep;
    logic zero_all;
  } tcw_cmd_t;

  typedef struct packed {
    logic scroll_due;
    logic sweep_last;
  } tcw_status_t;

endpackage

// ----- rtl/tcw_ram.sv -----
// generic single write port, single read port ram with registered read
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tcw_ctrl.sv -----
// controller state machine: clearing pass, scroll sweep and item acceptance
module tcw_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  tcw_pkg::tcw_status_t status,
  output tcw_pkg::tcw_cmd_t    cmd,
  output logic                 busy
);

  tcw_pkg::tcw_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcw_pkg::ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        if (start && status.scroll_due) begin
          state_nxt = tcw_pkg::ST_SCROLL;
        end
      end
      tcw_pkg::ST_CLEAR, tcw_pkg::ST_SCROLL: begin
        if (status.sweep_last) begin
          state_nxt = tcw_pkg::ST_DRAIN;
        end
      end
      tcw_pkg::ST_DRAIN: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      tcw_pkg::ST_IDLE: begin
        busy       = 1'b0;
        cmd.accept = start;
      end
      tcw_pkg::ST_CLEAR: begin
        cmd.sweep    = 1'b1;
        cmd.zero_all = 1'b1;
      end
      tcw_pkg::ST_SCROLL: begin
        cmd.sweep = 1'b1;
      end
      tcw_pkg::ST_DRAIN: begin
        busy = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/tcw_dp.sv -----
// datapath: screen ram, cursor, attribute register, sweep counter, result registers
module tcw_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tcw_pkg::tcw_cmd_t             cmd,
  output tcw_pkg::tcw_status_t          status,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::CHAR_W-1:0]    cfg_wdata,
  input  logic                          in_op,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::COL_W-1:0]     in_read_column,
  input  logic [tcw_pkg::ROW_W-1:0]     in_read_row,
  output logic                          out_strobe,
  output logic [tcw_pkg::CELL_W-1:0]    out_cell_value,
  output logic [tcw_pkg::COL_W-1:0]     out_cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]     out_cursor_row,
  output logic                          out_did_scroll
);

  logic [tcw_pkg::CHAR_W-1:0]    attr_r;
  logic [tcw_pkg::COL_W-1:0]     col_r, col_nxt;
  logic [tcw_pkg::CUR_ROW_W-1:0] row_r, row_nxt;
  logic [tcw_pkg::ADDR_W-1:0]    idx_r, idx_nxt;
  logic                          pend_r;
  logic [tcw_pkg::ADDR_W-1:0]    pend_addr_r;
  logic                          pend_zero_r;
  logic                          strobe_r, hit_r, scroll_r;

  logic                          ram_we;
  logic [tcw_pkg::ADDR_W-1:0]    ram_waddr, ram_raddr, cur_addr, item_raddr;
  logic [tcw_pkg::CELL_W-1:0]    ram_wdata, ram_rdata;
  logic                          col_end, row_end, in_range, item_write;

  assign col_end    = (col_r == tcw_pkg::COL_W'(tcw_pkg::COLUMNS - 1));
  assign row_end    = (row_r == tcw_pkg::CUR_ROW_W'(tcw_pkg::ROWS - 1));
  assign item_write = cmd.accept && (in_op == tcw_pkg::OP_WRITE);
  assign in_range   = (in_read_column < tcw_pkg::COL_W'(tcw_pkg::COLUMNS)) &&
                      ({2'b00, in_read_row} < 7'(tcw_pkg::ROWS));

  assign cur_addr   = tcw_pkg::ADDR_W'(row_r) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS) +
                      tcw_pkg::ADDR_W'(col_r);
  assign item_raddr = tcw_pkg::ADDR_W'(in_read_row) * tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS) +
                      tcw_pkg::ADDR_W'(in_read_column);

  assign status.scroll_due = (in_op == tcw_pkg::OP_WRITE) && col_end && row_end;
  assign status.sweep_last = (idx_r == tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1));

  // copy pipeline: read row below now, write the cell in the next cycle
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {in_char_code, attr_r};
    if (pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r;
      ram_wdata = pend_zero_r ? '0 : ram_rdata;
    end else if (item_write) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = cmd.sweep ? (idx_r + tcw_pkg::ADDR_W'(tcw_pkg::COLUMNS)) : item_raddr;
  assign idx_nxt   = (cmd.sweep && !status.sweep_last) ? idx_r + 1'b1 : '0;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (item_write) begin
      if (col_end) begin
        col_nxt = '0;
        if (!row_end) begin
          row_nxt = row_r + 1'b1;
        end
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(tcw_pkg::CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r   <= tcw_pkg::ATTR_RESET;
      col_r    <= '0;
      row_r    <= '0;
      idx_r    <= '0;
      pend_r   <= 1'b0;
      strobe_r <= 1'b0;
      hit_r    <= 1'b0;
      scroll_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      idx_r    <= idx_nxt;
      pend_r   <= cmd.sweep;
      strobe_r <= cmd.accept;
      hit_r    <= cmd.accept && (in_op == tcw_pkg::OP_READ) && in_range;
      scroll_r <= item_write && status.scroll_due;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= idx_r;
    pend_zero_r <= cmd.zero_all || (idx_r >= tcw_pkg::ADDR_W'(tcw_pkg::COPY_CELLS));
  end

  assign out_strobe        = strobe_r;
  assign out_cell_value    = hit_r ? ram_rdata : '0;
  assign out_cursor_column = col_r;
  assign out_cursor_row    = tcw_pkg::ROW_W'(row_r);
  assign out_did_scroll    = scroll_r;

endmodule

// ----- rtl/text_console_writer_unit.sv -----
// top level of the text console writer
// usage:
//   - an item is taken at a rising edge with start high and busy low
//   - in_op selects a character write at the cursor or a cell read at
//     (in_read_column, in_read_row); reads off the screen give zero
//   - the result shows on the out_ ports for one cycle with out_strobe,
//     in the cycle after the item is taken; the receiver cannot stall it
//   - writes and reads go at one item per cycle while busy stays low
//   - a write that wraps past the last row scrolls the screen: busy stays
//     high while the screen ram is accessed once per cell and the copy
//     pipeline drains; its result still comes in the cycle after it is
//     taken, with out_did_scroll set
//   - after reset the screen ram is cleared one cell per cycle while busy
//     is high; the cursor starts at column 0, row 0
//   - cfg_we writes cfg_wdata to the attribute register at any time; it
//     goes into the low byte of every character written, reset value 240
module text_console_writer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we,
  input  logic [tcw_pkg::CHAR_W-1:0]    cfg_wdata,
  input  logic                          in_op,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_char_code,
  input  logic [tcw_pkg::COL_W-1:0]     in_read_column,
  input  logic [tcw_pkg::ROW_W-1:0]     in_read_row,
  output logic                          out_strobe,
  output logic [tcw_pkg::CELL_W-1:0]    out_cell_value,
  output logic [tcw_pkg::COL_W-1:0]     out_cursor_column,
  output logic [tcw_pkg::ROW_W-1:0]     out_cursor_row,
  output logic                          out_did_scroll
);

  tcw_pkg::tcw_cmd_t    cmd;
  tcw_pkg::tcw_status_t status;

  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .status(status),
    .cmd   (cmd),
    .busy  (busy)
  );

  tcw_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_op            (in_op),
    .in_char_code     (in_char_code),
    .in_read_column   (in_read_column),
    .in_read_row      (in_read_row),
    .out_strobe       (out_strobe),
    .out_cell_value   (out_cell_value),
    .out_cursor_column(out_cursor_column),
    .out_cursor_row   (out_cursor_row),
    .out_did_scroll   (out_did_scroll)
  );

  // clearing pass holds off items right after reset
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // every result comes from a transaction taken in the previous cycle
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy))
    else $error("result without transaction");

  // a scroll result comes with its strobe and the sweep holds off input
  a_scroll_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_did_scroll |-> (out_strobe && busy))
    else $error("scroll reported without strobe or sweep");

endmodule
